// ===== design/hvn_pkg.sv =====
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared widths, codes and types of the heightmap vertex normal core.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MaxCols   = 1024;
  localparam int MaxRows   = 4096;
  localparam int ColW      = $clog2(MaxCols);
  localparam int RowW      = $clog2(MaxRows);
  localparam int HeightW   = 16;
  localparam int NormW     = 16;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 13;
  localparam int ColsCfgW  = 11;
  localparam int RowsCfgW  = 13;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_COLS = 2'd0,
    CFG_FRAME_ROWS = 2'd1
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_READ = 8'b0000_0010,
    ST_LOAD = 8'b0000_0100,
    ST_SUM  = 8'b0000_1000,
    ST_SQ   = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_SQRT = 8'b0100_0000,
    ST_PUSH = 8'b1000_0000
  } state_e;

  // one row store word: row r-2 above, row r-1 below
  typedef struct packed {
    logic [HeightW-1:0] older;
    logic [HeightW-1:0] newer;
  } row_word_t;

endpackage

// ===== design/hvn_if.sv =====
// ----------------------------------------------------------------------------
// hvn_if
// Valid/ready channels of the core: height samples in, normals out.
// ----------------------------------------------------------------------------
interface hvn_in_if import hvn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HeightW-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface hvn_out_if import hvn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NormW-1:0] normal_x;
  logic signed [NormW-1:0] normal_y;
  logic signed [NormW-1:0] normal_z;
  logic [ColW-1:0]         point_col;
  logic [RowW-1:0]         point_row;
  logic                    run_last;
  logic                    frame_end;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  output point_col, output point_row, output run_last,
                  output frame_end, input ready);
  modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                  input point_col, input point_row, input run_last,
                  input frame_end, output ready);
endinterface

// ===== design/heightmap_vertex_normals_core.sv =====
// ----------------------------------------------------------------------------
// heightmap_vertex_normals_core
// Streaming unit normals of a heightmap grid from raster-order samples.
// ----------------------------------------------------------------------------
// Height samples (unsigned Q8.8) enter on sample_i in raster order, column
// fastest. Normals leave on normal_o as signed Q1.14 with their grid point,
// a run_last flag on the last normal an item causes, and frame_end on the
// normal of the final grid point. A normal is emitted once its neighborhood
// has arrived; the last row is flushed along with its own samples.
// One item is worked on at a time: it is accepted, the row store is read and
// the window is updated, then per normal come the sum, four square steps on
// a shared multiplier, per component a 31-step division and a 16-step square
// root, and the push.
// The row store (two rows in one 32-bit wide memory) is read and written
// once per item at the column address.
// The result sits in an output register; the next normal is computed while
// it waits, and the sequencer holds in the push step when the receiver stalls.
// Reset clears counters, window and output valid; frame size is 1024 x 1024.
// A configuration write restarts the frame at (0, 0); the user must write only while idle (the core does not check).
// ----------------------------------------------------------------------------
module heightmap_vertex_normals_core import hvn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  hvn_in_if.sink              sample_i,
  hvn_out_if.source           normal_o
);

  localparam int SumW = 21;
  localparam int MagW = SumW - 1;
  localparam int SqW  = 2 * MagW;
  localparam int SW   = SqW + 2;
  localparam int QW   = 31;
  localparam int RootW = 16;
  localparam int SremW = RootW + 2;

  state_e state_q, state_d;

  logic [ColW-1:0] cols_last_q;
  logic [RowW-1:0] rows_last_q;
  logic [ColW-1:0] col_q, cur_c_q;
  logic [RowW-1:0] row_q, cur_r_q;
  logic [HeightW-1:0] h_q;
  logic [HeightW-1:0] win_q [3][3];
  logic [3:0] pend_q;
  logic [1:0] slot_q;

  row_word_t mem [MaxCols];
  row_word_t rdata_q;

  logic signed [SumW-1:0] n_q [3];
  logic [SqW-1:0]  sq_q [3];
  logic [SW-1:0]   s_q;
  logic [1:0]      comp_q;
  logic [4:0]      cnt_q;
  logic [SW-1:0]   rem_q;
  logic [QW-1:0]   quo_q;
  logic [31:0]     src_q;
  logic [RootW-1:0] root_q;
  logic [SremW-1:0] srem_q;
  logic signed [NormW-1:0] res_q [3];
  logic [ColW-1:0] px_q;
  logic [RowW-1:0] py_q;

  logic                    ov_q;
  logic signed [NormW-1:0] ox_q, oy_q, oz_q;
  logic [ColW-1:0]         ocol_q;
  logic [RowW-1:0]         orow_q;
  logic                    olast_q, oend_q;

  logic in_acc, out_take, push_ok;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_acc   = sample_i.valid && sample_i.ready;
  assign out_take = ov_q && normal_o.ready;
  assign push_ok  = (state_q == ST_PUSH) && (!ov_q || normal_o.ready);

  // row store: read on accept, write back in the load step
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= mem[col_q];
    end
    if (state_q == ST_LOAD) begin
      mem[cur_c_q] <= '{older: rdata_q.newer, newer: h_q};
    end
  end

  // --------------------------------------------------------------------------
  // neighborhood sum for the current slot
  // --------------------------------------------------------------------------
  logic [1:0] slot_next;
  logic [ColW-1:0] px_c;
  logic [RowW-1:0] py_c;
  logic [HeightW-1:0] v [3][3];
  logic [2:0] colok, rowok;
  logic [5:0] eok;
  logic signed [HeightW:0] dd [6];
  logic signed [SumW-1:0] nx_c, nz_c, d1, d2;
  logic [3:0] ntri;

  always_comb begin
    priority if (pend_q[0]) slot_next = 2'd0;
    else if (pend_q[1])     slot_next = 2'd1;
    else if (pend_q[2])     slot_next = 2'd2;
    else                    slot_next = 2'd3;
  end

  always_comb begin
    logic [1:0] a, b;
    px_c = slot_next[0] ? cur_c_q : cur_c_q - 1'b1;
    py_c = slot_next[1] ? cur_r_q : cur_r_q - 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a = 2'(i) + {1'b0, slot_next[0]};
        b = 2'(j) + {1'b0, slot_next[1]};
        v[i][j] = (a != 2'd3 && b != 2'd3) ? win_q[a][b] : '0;
      end
    end
    colok = {px_c != cols_last_q, 1'b1, px_c != '0};
    rowok = {py_c != rows_last_q, 1'b1, py_c != '0};
    // edges in fan order: (0,-1) (-1,0) (-1,1) (0,1) (1,0) (1,-1)
    eok[0] = rowok[0];
    eok[1] = colok[0];
    eok[2] = colok[0] && rowok[2];
    eok[3] = rowok[2];
    eok[4] = colok[2];
    eok[5] = colok[2] && rowok[0];
    dd[0] = $signed({1'b0, v[1][0]}) - $signed({1'b0, v[1][1]});
    dd[1] = $signed({1'b0, v[0][1]}) - $signed({1'b0, v[1][1]});
    dd[2] = $signed({1'b0, v[0][2]}) - $signed({1'b0, v[1][1]});
    dd[3] = $signed({1'b0, v[1][2]}) - $signed({1'b0, v[1][1]});
    dd[4] = $signed({1'b0, v[2][1]}) - $signed({1'b0, v[1][1]});
    dd[5] = $signed({1'b0, v[2][0]}) - $signed({1'b0, v[1][1]});
    nx_c = '0;
    nz_c = '0;
    ntri = '0;
    for (int t = 0; t < 6; t++) begin
      d1 = SumW'(dd[t]);
      d2 = SumW'(dd[(t + 1) % 6]);
      if (eok[t] && eok[(t + 1) % 6]) begin
        ntri = ntri + 1'b1;
        unique case (t)
          0: begin nx_c = nx_c + d2;      nz_c = nz_c + d1;      end
          1: begin nx_c = nx_c + d1;      nz_c = nz_c + d1 - d2; end
          2: begin nx_c = nx_c + d1 - d2; nz_c = nz_c - d2;      end
          3: begin nx_c = nx_c - d2;      nz_c = nz_c - d1;      end
          4: begin nx_c = nx_c - d1;      nz_c = nz_c + d2 - d1; end
          default: begin nx_c = nx_c + d2 - d1; nz_c = nz_c + d2; end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // square, divide and root step logic
  // --------------------------------------------------------------------------
  logic signed [SumW-1:0] ncur;
  logic [MagW-1:0] mag;
  logic [SqW-1:0]  prod;
  assign ncur = n_q[comp_q];
  assign mag  = ncur[SumW-1] ? MagW'(-ncur) : MagW'(ncur);
  assign prod = mag * mag;

  logic [SW:0]   rem_sh;
  logic          div_ge;
  logic [QW-1:0] quo_d;
  assign rem_sh = {rem_q, (cnt_q == '0) ? sq_q[comp_q][0] : 1'b0};
  assign div_ge = rem_sh >= {1'b0, s_q};
  assign quo_d  = {quo_q[QW-2:0], div_ge};

  logic [SremW+1:0] srsh, trial;
  logic             sq_ge;
  logic [RootW-1:0] root_d;
  logic [RootW:0]   rnd;
  logic [NormW-1:0] lmag;
  assign srsh  = {srem_q, src_q[31:30]};
  assign trial = {2'b00, root_q, 2'b01};
  assign sq_ge = srsh >= trial;
  assign root_d = {root_q[RootW-2:0], sq_ge};
  // nearest by half steps: (root + 1) / 2
  assign rnd  = {1'b0, root_d} + 1'b1;
  assign lmag = NormW'(rnd[RootW:1]);

  logic last_c;
  assign last_c = (pend_q & ~(4'b0001 << slot_q)) == 4'b0000;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_READ;
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_SUM;
      ST_SUM:  state_d = (pend_q == '0) ? ST_IDLE : ST_SQ;
      ST_SQ:   if (comp_q == 2'd3) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 5'(QW - 1)) state_d = ST_SQRT;
      ST_SQRT: begin
        if (cnt_q == 5'(RootW - 1)) state_d = (comp_q == 2'd2) ? ST_PUSH : ST_DIV;
      end
      ST_PUSH: if (push_ok) state_d = last_c ? ST_IDLE : ST_SUM;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cols_last_q <= ColW'(MaxCols - 1);
      rows_last_q <= RowW'(1024 - 1);
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= '0;
      ov_q        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (push_ok) ov_q <= 1'b1;
      else if (out_take) ov_q <= 1'b0;
      if (cfg_we_i && (cfg_idx_i == CFG_FRAME_COLS || cfg_idx_i == CFG_FRAME_ROWS)) begin
        if (cfg_idx_i == CFG_FRAME_COLS) begin
          priority if (cfg_data_i[ColsCfgW-1:0] < ColsCfgW'(2)) cols_last_q <= ColW'(1);
          else if (cfg_data_i[ColsCfgW-1:0] > ColsCfgW'(MaxCols))
            cols_last_q <= ColW'(MaxCols - 1);
          else cols_last_q <= ColW'(cfg_data_i[ColsCfgW-1:0] - 1'b1);
        end else begin
          priority if (cfg_data_i[RowsCfgW-1:0] < RowsCfgW'(2)) rows_last_q <= RowW'(1);
          else if (cfg_data_i[RowsCfgW-1:0] > RowsCfgW'(MaxRows))
            rows_last_q <= RowW'(MaxRows - 1);
          else rows_last_q <= RowW'(cfg_data_i[RowsCfgW-1:0] - 1'b1);
        end
        col_q <= '0;
        row_q <= '0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            win_q[i][j] <= '0;
          end
        end
      end
      if (state_q == ST_LOAD) begin
        for (int k = 0; k < 3; k++) begin
          win_q[0][k] <= win_q[1][k];
          win_q[1][k] <= win_q[2][k];
        end
        win_q[2][0] <= rdata_q.older;
        win_q[2][1] <= rdata_q.newer;
        win_q[2][2] <= h_q;
        pend_q[0] <= (cur_r_q != '0) && (cur_c_q != '0);
        pend_q[1] <= (cur_r_q != '0) && (cur_c_q == cols_last_q);
        pend_q[2] <= (cur_r_q == rows_last_q) && (cur_c_q != '0);
        pend_q[3] <= (cur_r_q == rows_last_q) && (cur_c_q == cols_last_q);
        if (cur_c_q == cols_last_q) begin
          col_q <= '0;
          row_q <= (cur_r_q == rows_last_q) ? '0 : cur_r_q + 1'b1;
        end else begin
          col_q <= cur_c_q + 1'b1;
        end
      end
      if (push_ok) begin
        pend_q[slot_q] <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      h_q     <= sample_i.height;
      cur_c_q <= col_q;
      cur_r_q <= row_q;
    end
    unique case (state_q)
      ST_SUM: begin
        slot_q <= slot_next;
        px_q   <= px_c;
        py_q   <= py_c;
        n_q[0] <= nx_c;
        n_q[1] <= SumW'({ntri, 8'h00});
        n_q[2] <= nz_c;
        comp_q <= '0;
      end
      ST_SQ: begin
        if (comp_q == 2'd3) begin
          comp_q <= '0;
          cnt_q  <= '0;
          rem_q  <= SW'(sq_q[0][SqW-1:1]);
        end else begin
          sq_q[comp_q] <= prod;
          comp_q       <= comp_q + 1'b1;
          if (comp_q == 2'd2) begin
            s_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(prod);
          end
        end
      end
      ST_DIV: begin
        rem_q <= div_ge ? SW'(rem_sh - {1'b0, s_q}) : SW'(rem_sh);
        quo_q <= quo_d;
        if (cnt_q == 5'(QW - 1)) begin
          cnt_q  <= '0;
          src_q  <= {1'b0, quo_d};
          root_q <= '0;
          srem_q <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      ST_SQRT: begin
        srem_q <= sq_ge ? SremW'(srsh - trial) : SremW'(srsh);
        root_q <= root_d;
        src_q  <= {src_q[29:0], 2'b00};
        if (cnt_q == 5'(RootW - 1)) begin
          res_q[comp_q] <= ncur[SumW-1] ? -$signed(lmag) : $signed(lmag);
          cnt_q  <= '0;
          comp_q <= comp_q + 1'b1;
          if (comp_q != 2'd2) rem_q <= SW'(sq_q[comp_q + 1'b1][SqW-1:1]);
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      ST_PUSH: begin
        if (push_ok) begin
          ox_q    <= res_q[0];
          oy_q    <= res_q[1];
          oz_q    <= res_q[2];
          ocol_q  <= px_q;
          orow_q  <= py_q;
          olast_q <= last_c;
          oend_q  <= (px_q == cols_last_q) && (py_q == rows_last_q);
        end
      end
      default: ;
    endcase
  end

  assign normal_o.valid     = ov_q;
  assign normal_o.normal_x  = ox_q;
  assign normal_o.normal_y  = oy_q;
  assign normal_o.normal_z  = oz_q;
  assign normal_o.point_col = ocol_q;
  assign normal_o.point_row = orow_q;
  assign normal_o.run_last  = olast_q;
  assign normal_o.frame_end = oend_q;

endmodule

// ===== design/hvn_checker.sv =====
// ----------------------------------------------------------------------------
// hvn_checker
// Port-level checks of the heightmap vertex normal core.
// ----------------------------------------------------------------------------
module hvn_checker import hvn_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [NormW-1:0] normal_x_i,
  input logic signed [NormW-1:0] normal_y_i,
  input logic                    run_last_i,
  input logic                    frame_end_i
);

  // a stalled normal stays valid and keeps its x component
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(normal_x_i))
    else $error("stalled normal changed");

  // one sample at a time: ready drops once a sample is taken
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken back to back");

  // the final grid point closes its run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> run_last_i)
    else $error("frame end without run last");

  // every fan triangle tilts the normal upward
  a_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> normal_y_i > 0 && normal_y_i <= 16'sd16384)
    else $error("normal y out of range");

endmodule

bind heightmap_vertex_normals_core hvn_checker u_hvn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (normal_o.valid),
  .out_ready_i (normal_o.ready),
  .normal_x_i  (normal_o.normal_x),
  .normal_y_i  (normal_o.normal_y),
  .run_last_i  (normal_o.run_last),
  .frame_end_i (normal_o.frame_end)
);
